### rtl/crt_pkg.sv
// Package for the CSV record tokenizer: item and result types, configuration
// register layout, register indexes and the byte constants of the format.
// No dependencies.
`default_nettype none

package crt_pkg;

  // Fixed bytes of the CSV format.
  localparam logic [7:0] QUOTE_BYTE   = 8'h22;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIELD_SEPARATOR   = 3'd0,
    CFG_COMMENT_MARKER    = 3'd1,
    CFG_QUOTED_SEP_EN     = 3'd2,
    CFG_QUOTED_NL_EN      = 3'd3,
    CFG_COMMENT_EN        = 3'd4,
    CFG_BLANK_SKIP_EN     = 3'd5
  } cfg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [7:0] FIELD_SEPARATOR_RST = 8'd44;
  localparam logic [7:0] COMMENT_MARKER_RST  = 8'd35;

  typedef struct packed {
    logic [7:0] field_separator;
    logic [7:0] comment_marker;
    logic       quoted_separator_enable;
    logic       quoted_newline_enable;
    logic       comment_enable;
    logic       blank_skip_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } item_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       cell_end;
    logic       row_end;
  } result_t;

  // Per-record parser flags.
  typedef struct packed {
    logic quote_odd;
    logic at_record_start;
    logic skipping_comment;
    logic cell_nonempty;
  } flags_t;

  localparam flags_t FLAGS_RST = '{quote_odd: 1'b0, at_record_start: 1'b1,
                                   skipping_comment: 1'b0, cell_nonempty: 1'b0};

endpackage

`default_nettype wire

### rtl/crt_stream_ifs.sv
// Valid/ready stream interfaces for the input item and result channels.
// Does not depend on crt_pkg; the field widths are written out here.
`default_nettype none

interface crt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface crt_out_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] out_byte;
  logic       cell_end;
  logic       row_end;

  modport source (output valid, output has_byte, output out_byte, output cell_end,
                  output row_end, input ready);
  modport sink   (input valid, input has_byte, input out_byte, input cell_end,
                  input row_end, output ready);
endinterface

`default_nettype wire

### rtl/csv_record_tokenizer_core.sv
// CSV record tokenizer top level: input register, per-byte step logic, result register.
// An item waits in the input register until the result register has a free slot for its result.
// Throughput: one item per cycle while the result register is not stalled by the output channel.
// Items that cause no result pass through without occupying the result register.
// Reset (synchronous, active low) clears the pipeline valids and record flags and
// loads the configuration registers with their default values.
`default_nettype none

module csv_record_tokenizer_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  crt_in_if.sink                             in_ch,
  crt_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [crt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [crt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import crt_pkg::*;

  cfg_t    cfg;
  logic    s0_valid_r;
  item_t   s0_item_r;
  logic    s0_go;
  result_t step_res;
  logic    step_present;
  logic    slot_free;

  crt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held item moves on when it makes no result or the result slot is free.
  assign s0_go       = s0_valid_r && (slot_free || !step_present);
  assign in_ch.ready = !s0_valid_r || s0_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s0_item_r.in_byte      <= in_ch.in_byte;
      s0_item_r.end_of_input <= in_ch.end_of_input;
    end
  end

  crt_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (s0_go),
    .item        (s0_item_r),
    .cfg         (cfg),
    .res         (step_res),
    .res_present (step_present)
  );

  crt_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s0_go && step_present),
    .res       (step_res),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

  // A content byte never ends a cell or a row.
  a_byte_not_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.has_byte && (out_ch.cell_end || out_ch.row_end)))
    else $error("content byte carries a cell or row end");

  // Without a content byte the byte field is zero.
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.has_byte) |-> (out_ch.out_byte == 8'd0))
    else $error("out_byte nonzero without has_byte");

  // A held item that has a result but no free slot stays in the input register.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && step_present && !slot_free) |=> (s0_valid_r && $stable(s0_item_r)))
    else $error("stalled item lost from input register");

  // The input register is never refilled while its item is stuck.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && !s0_go) |-> !in_ch.ready)
    else $error("input accepted over a stalled item");

endmodule

`default_nettype wire

### rtl/crt_cfg_regs.sv
// Configuration registers of the tokenizer, written through a plain write port.
// Depends on crt_pkg.
`default_nettype none

module crt_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [crt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [crt_pkg::CFG_DATA_W-1:0] cfg_data,
  output crt_pkg::cfg_t                      cfg
);
  import crt_pkg::*;

  cfg_t cfg_r;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.field_separator         <= FIELD_SEPARATOR_RST;
      cfg_r.comment_marker          <= COMMENT_MARKER_RST;
      cfg_r.quoted_separator_enable <= 1'b1;
      cfg_r.quoted_newline_enable   <= 1'b1;
      cfg_r.comment_enable          <= 1'b1;
      cfg_r.blank_skip_enable       <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FIELD_SEPARATOR: cfg_r.field_separator         <= cfg_data;
        CFG_COMMENT_MARKER:  cfg_r.comment_marker          <= cfg_data;
        CFG_QUOTED_SEP_EN:   cfg_r.quoted_separator_enable <= cfg_data[0];
        CFG_QUOTED_NL_EN:    cfg_r.quoted_newline_enable   <= cfg_data[0];
        CFG_COMMENT_EN:      cfg_r.comment_enable          <= cfg_data[0];
        CFG_BLANK_SKIP_EN:   cfg_r.blank_skip_enable       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### rtl/crt_step.sv
// Per-byte tokenizer logic: record flags and the result decision for one item.
// Depends on crt_pkg.
`default_nettype none

module crt_step (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            advance,
  input  wire crt_pkg::item_t  item,
  input  wire crt_pkg::cfg_t   cfg,
  output crt_pkg::result_t     res,
  output logic                 res_present
);
  import crt_pkg::*;

  flags_t flags_r;
  flags_t flags_nxt;

  // Classify the byte and decide the result and the next flags.
  always_comb begin
    logic is_nl;
    logic is_quote;
    logic is_sep;
    logic at_start_comment;
    is_nl    = (item.in_byte == NEWLINE_BYTE);
    is_quote = (item.in_byte == QUOTE_BYTE);
    is_sep   = (item.in_byte == cfg.field_separator);
    at_start_comment = cfg.comment_enable && (item.in_byte == cfg.comment_marker);

    flags_nxt   = flags_r;
    res_present = 1'b0;
    res         = '0;

    if (item.end_of_input) begin
      // Close an open record; a pending comment or empty start gives nothing.
      flags_nxt    = FLAGS_RST;
      res_present  = !flags_r.at_record_start && !flags_r.skipping_comment;
      res.cell_end = flags_r.cell_nonempty;
      res.row_end  = 1'b1;
    end else if (flags_r.skipping_comment) begin
      if (is_nl) flags_nxt = FLAGS_RST;
    end else if (flags_r.at_record_start && is_nl) begin
      // Blank record: skipped, or an empty row.
      if (!cfg.blank_skip_enable) begin
        flags_nxt   = FLAGS_RST;
        res_present = 1'b1;
        res.row_end = 1'b1;
      end
    end else if (flags_r.at_record_start && at_start_comment) begin
      flags_nxt.at_record_start  = 1'b0;
      flags_nxt.skipping_comment = 1'b1;
    end else begin
      flags_nxt.at_record_start = 1'b0;
      if (is_quote) flags_nxt.quote_odd = !flags_r.quote_odd;
      res_present = 1'b1;
      if (is_nl && !(flags_r.quote_odd && cfg.quoted_newline_enable)) begin
        // Record end; the parity is dropped even when odd.
        flags_nxt    = FLAGS_RST;
        res.cell_end = flags_r.cell_nonempty;
        res.row_end  = 1'b1;
      end else if (!is_nl && is_sep &&
                   !(flags_r.quote_odd && cfg.quoted_separator_enable)) begin
        flags_nxt.cell_nonempty = 1'b0;
        res.cell_end = 1'b1;
      end else begin
        // Content byte, including quoted newlines and separators.
        flags_nxt.cell_nonempty = 1'b1;
        res.has_byte = 1'b1;
        res.out_byte = item.in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= FLAGS_RST;
    end else if (advance) begin
      flags_r <= flags_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/crt_out_reg.sv
// Result register that drives the output channel and frees itself on a take.
// Depends on crt_pkg and crt_out_if.
`default_nettype none

module crt_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire crt_pkg::result_t res,
  output logic                  slot_free,
  crt_out_if.source             out_ch
);
  import crt_pkg::*;

  logic    valid_r;
  result_t res_r;

  // The slot can take a new result when empty or when its item leaves now.
  assign slot_free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && slot_free) begin
      res_r <= res;
    end
  end

  assign out_ch.valid    = valid_r;
  assign out_ch.has_byte = res_r.has_byte;
  assign out_ch.out_byte = res_r.out_byte;
  assign out_ch.cell_end = res_r.cell_end;
  assign out_ch.row_end  = res_r.row_end;

endmodule

`default_nettype wire
